// ===== hw/rtl/drpu_pkg.sv =====
// Package for the dead-reckoning position update block.
// Holds the CORDIC word widths, gain and arc-tangent constants, and the cell payload type.
// No dependencies.
`timescale 1ns / 1ps

package drpu_pkg;

    // Rotator word: distance * K in units of 2^-38 m, with headroom for CORDIC growth.
    localparam int DATA_W    = 48;
    // Angle held as a 32-bit fraction of a full turn.
    localparam int Z_W       = 32;
    // Fraction bits dropped when the rotated vector returns to the Q.8 grid.
    localparam int FRAC_DROP = 30;
    // Width of the rounded increment.
    localparam int INC_W     = DATA_W - FRAC_DROP;
    // Number of arc-tangent entries available.
    localparam int TABLE_LEN = 24;

    // CORDIC gain compensation K in unsigned Q0.30.
    localparam int GAIN_W = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

    localparam logic [Z_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [Z_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // round(atan(2^-i) / (2*pi) * 2^32) for each stage.
    localparam logic [Z_W-1:0] ARC_TABLE [TABLE_LEN] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    // Vector and residual angle handed from one cell to the next.
    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic        [Z_W-1:0]    z;
    } cordic_t;

endpackage

// ===== hw/rtl/drpu_pre.sv =====
// Entry stage: scales the distance by the CORDIC gain and folds the heading into range.
// Depends on drpu_pkg.
`timescale 1ns / 1ps

module drpu_pre #(
    parameter int POS_WIDTH  = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [POS_WIDTH-1:0]    old_x,
    input  logic signed [POS_WIDTH-1:0]    old_y,
    input  logic signed [15:0]             distance,
    input  logic        [15:0]             heading,
    output logic                           out_valid,
    output drpu_pkg::cordic_t              out_vec,
    output logic signed [POS_WIDTH-1:0]    out_px,
    output logic signed [POS_WIDTH-1:0]    out_py
);

    localparam int ZW = drpu_pkg::Z_W;
    localparam logic [ZW-1:0] HEAD_MASK = ZW'((64'd1 << ANGLE_BITS) - 64'd1);

    logic                           valid_reg;
    drpu_pkg::cordic_t              vec_reg;
    drpu_pkg::cordic_t              vec_next;
    logic signed [POS_WIDTH-1:0]    px_reg;
    logic signed [POS_WIDTH-1:0]    py_reg;

    logic        [ZW-1:0]                 z_raw;
    logic        [ZW-1:0]                 z_turn;
    logic signed [drpu_pkg::GAIN_W+16:0]  prod;
    logic signed [drpu_pkg::DATA_W-1:0]   x_start;

    // Gain-scaled start vector and the heading as a fraction of a turn.
    always_comb
    begin
        z_raw   = ({{(ZW-16){1'b0}}, heading} & HEAD_MASK) << (ZW - ANGLE_BITS);
        z_turn  = z_raw + drpu_pkg::QUARTER_TURN;
        prod    = $signed(distance) * $signed({1'b0, drpu_pkg::GAIN_Q30});
        x_start = drpu_pkg::DATA_W'(prod);
        vec_next.y = '0;
        // Headings in the left half-plane are turned by half a turn with the vector negated.
        if (z_turn[ZW-1])
        begin
            vec_next.x = -x_start;
            vec_next.z = z_raw - drpu_pkg::HALF_TURN;
        end
        else
        begin
            vec_next.x = x_start;
            vec_next.z = z_raw;
        end
    end

    // Valid flag under reset; payload registers load on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            vec_reg <= vec_next;
            px_reg  <= old_x;
            py_reg  <= old_y;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_px    = px_reg;
    assign out_py    = py_reg;

endmodule

// ===== hw/rtl/drpu_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation by atan(2^-STAGE), registered.
// Carries the old position along with the vector. Depends on drpu_pkg.
`timescale 1ns / 1ps

module drpu_cell #(
    parameter int STAGE     = 0,
    parameter int POS_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  drpu_pkg::cordic_t              in_vec,
    input  logic signed [POS_WIDTH-1:0]    in_px,
    input  logic signed [POS_WIDTH-1:0]    in_py,
    output logic                           out_valid,
    output drpu_pkg::cordic_t              out_vec,
    output logic signed [POS_WIDTH-1:0]    out_px,
    output logic signed [POS_WIDTH-1:0]    out_py
);

    logic                           valid_reg;
    drpu_pkg::cordic_t              vec_reg;
    drpu_pkg::cordic_t              vec_next;
    logic signed [POS_WIDTH-1:0]    px_reg;
    logic signed [POS_WIDTH-1:0]    py_reg;

    logic signed [drpu_pkg::DATA_W-1:0] xs;
    logic signed [drpu_pkg::DATA_W-1:0] ys;

    // Rotate towards zero residual angle; shifts round toward minus infinity.
    always_comb
    begin
        xs = in_vec.x >>> STAGE;
        ys = in_vec.y >>> STAGE;
        if (in_vec.z[drpu_pkg::Z_W-1])
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + drpu_pkg::ARC_TABLE[STAGE];
        end
        else
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - drpu_pkg::ARC_TABLE[STAGE];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            vec_reg <= vec_next;
            px_reg  <= in_px;
            py_reg  <= in_py;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_px    = px_reg;
    assign out_py    = py_reg;

endmodule

// ===== hw/rtl/drpu_post.sv =====
// Exit stage: rounds the rotated vector to the Q.8 grid, adds it to the old position
// and saturates each sum. Depends on drpu_pkg.
`timescale 1ns / 1ps

module drpu_post #(
    parameter int POS_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  drpu_pkg::cordic_t              in_vec,
    input  logic signed [POS_WIDTH-1:0]    in_px,
    input  logic signed [POS_WIDTH-1:0]    in_py,
    output logic                           done,
    output logic signed [POS_WIDTH-1:0]    new_x,
    output logic signed [POS_WIDTH-1:0]    new_y,
    output logic                           saturated
);

    localparam int SUM_W = POS_WIDTH + 1;
    localparam int DW    = drpu_pkg::DATA_W;
    localparam int IW    = drpu_pkg::INC_W;
    localparam logic signed [DW-1:0] ROUND_HALF = DW'(64'd1 << (drpu_pkg::FRAC_DROP - 1));
    localparam logic [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    logic                           done_reg;
    logic signed [POS_WIDTH-1:0]    x_reg;
    logic signed [POS_WIDTH-1:0]    x_next;
    logic signed [POS_WIDTH-1:0]    y_reg;
    logic signed [POS_WIDTH-1:0]    y_next;
    logic                           sat_reg;
    logic                           sat_next;

    logic signed [DW-1:0]     vx;
    logic signed [DW-1:0]     vy;
    logic        [IW-1:0]     inc_x;
    logic        [IW-1:0]     inc_y;
    logic        [SUM_W-1:0]  sum_x;
    logic        [SUM_W-1:0]  sum_y;
    logic                     ovf_x;
    logic                     ovf_y;

    // Round half up, add to the old position, clamp on overflow.
    always_comb
    begin
        vx    = in_vec.x + ROUND_HALF;
        vy    = in_vec.y + ROUND_HALF;
        inc_x = vx[DW-1:drpu_pkg::FRAC_DROP];
        inc_y = vy[DW-1:drpu_pkg::FRAC_DROP];
        sum_x = {in_px[POS_WIDTH-1], in_px} + {{(SUM_W-IW){inc_x[IW-1]}}, inc_x};
        sum_y = {in_py[POS_WIDTH-1], in_py} + {{(SUM_W-IW){inc_y[IW-1]}}, inc_y};
        ovf_x = sum_x[SUM_W-1] ^ sum_x[SUM_W-2];
        ovf_y = sum_y[SUM_W-1] ^ sum_y[SUM_W-2];
        if (ovf_x)
        begin
            x_next = sum_x[SUM_W-1] ? POS_MIN : POS_MAX;
        end
        else
        begin
            x_next = sum_x[POS_WIDTH-1:0];
        end
        if (ovf_y)
        begin
            y_next = sum_y[SUM_W-1] ? POS_MIN : POS_MAX;
        end
        else
        begin
            y_next = sum_y[POS_WIDTH-1:0];
        end
        sat_next = ovf_x | ovf_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            sat_reg <= sat_next;
        end
    end

    assign done      = done_reg;
    assign new_x     = x_reg;
    assign new_y     = y_reg;
    assign saturated = sat_reg;

endmodule

// ===== hw/rtl/dead_reckoning_position_update.sv =====
// Top level of the dead-reckoning position update: entry stage, a chain of CORDIC cells
// and the rounding/saturating exit stage. Depends on drpu_pkg, drpu_pre, drpu_cell, drpu_post.
//
//  Channel   | Handshake           | Payload
//  ----------+---------------------+----------------------------------------
//  command   | start, busy         | old_x, old_y, distance, heading
//  result    | done (strobe)       | new_x, new_y, saturated
//
// A transaction is taken on every cycle that start is high; busy is never raised.
// Each result passes through the entry register, one register per CORDIC cell and the
// exit register, and the chain never stalls, so one transaction per cycle is sustained.
// The result is shown for a single cycle with done; the receiver cannot stall it.
// Reset clears only the valid flags travelling down the chain.
`timescale 1ns / 1ps

module dead_reckoning_position_update #(
    parameter int ITERATIONS = 16,
    parameter int POS_WIDTH  = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [POS_WIDTH-1:0]    old_x,
    input  logic signed [POS_WIDTH-1:0]    old_y,
    input  logic signed [15:0]             distance,
    input  logic        [15:0]             heading,
    output logic                           done,
    output logic signed [POS_WIDTH-1:0]    new_x,
    output logic signed [POS_WIDTH-1:0]    new_y,
    output logic                           saturated
);

    localparam int LATENCY = ITERATIONS + 2;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    logic                           accept;
    logic                           chain_valid [ITERATIONS+1];
    drpu_pkg::cordic_t              chain_vec   [ITERATIONS+1];
    logic signed [POS_WIDTH-1:0]    chain_px    [ITERATIONS+1];
    logic signed [POS_WIDTH-1:0]    chain_py    [ITERATIONS+1];

    // The pipeline advances every cycle, so a command is never refused.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    drpu_pre #(
        .POS_WIDTH  (POS_WIDTH),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .old_x     (old_x),
        .old_y     (old_y),
        .distance  (distance),
        .heading   (heading),
        .out_valid (chain_valid[0]),
        .out_vec   (chain_vec[0]),
        .out_px    (chain_px[0]),
        .out_py    (chain_py[0])
    );

    // One rotation cell per CORDIC iteration.
    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_cell
        drpu_cell #(
            .STAGE     (g),
            .POS_WIDTH (POS_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_vec    (chain_vec[g]),
            .in_px     (chain_px[g]),
            .in_py     (chain_py[g]),
            .out_valid (chain_valid[g+1]),
            .out_vec   (chain_vec[g+1]),
            .out_px    (chain_px[g+1]),
            .out_py    (chain_py[g+1])
        );
    end

    drpu_post #(
        .POS_WIDTH (POS_WIDTH)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[ITERATIONS]),
        .in_vec    (chain_vec[ITERATIONS]),
        .in_px     (chain_px[ITERATIONS]),
        .in_py     (chain_py[ITERATIONS]),
        .done      (done),
        .new_x     (new_x),
        .new_y     (new_y),
        .saturated (saturated)
    );

    // Every accepted transaction yields a result after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("command was not followed by a result");

    // No result appears without a command the fixed latency earlier.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching command");

    // A saturated result has at least one coordinate pinned to a rail.
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (new_x == POS_MAX || new_x == POS_MIN ||
                                 new_y == POS_MAX || new_y == POS_MIN))
        else $error("saturation flag without a clamped coordinate");

endmodule
